// ----- hw/rtl/sse_pkg.sv -----
// Package with the types, constants and rounding helpers of the serendipity shape evaluator.
`default_nettype none

package sse_pkg;

  localparam int FRAC_BITS = 14;
  localparam int ONE = 1 << FRAC_BITS;

  localparam int COORD_W = 16;
  localparam int CW = COORD_W + 2;
  localparam int PROD_W = 2 * CW;
  localparam int ACC_W = PROD_W - FRAC_BITS + 6;
  localparam int OUT_W = 17;

  localparam int LIM_RAW = 3 << FRAC_BITS;
  localparam int LIM = (LIM_RAW > 65535) ? 65535 : LIM_RAW;

  localparam int NODES = 8;
  localparam int NODE_W = $clog2(NODES);
  localparam int CNT_W = 4;
  localparam int MASK_W = 4;

  localparam int IN_DATA_W = 40;
  localparam int OUT_DATA_W = 56;

  // Must be a power of two so that the pointers wrap by themselves.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic MODE_LINE = 1'b0;
  localparam logic MODE_QUAD = 1'b1;

  localparam logic [CNT_W-1:0] LINE_NODES_2 = CNT_W'(2);
  localparam logic [CNT_W-1:0] LINE_NODES_3 = CNT_W'(3);
  localparam logic [CNT_W-1:0] QUAD_NODES_4 = CNT_W'(4);
  localparam logic [CNT_W-1:0] QUAD_NODES_8 = CNT_W'(8);

  typedef logic [NODES-1:0][ACC_W-1:0] acc_vec_t;

  typedef struct packed {
    logic             bad;
    logic [CNT_W-1:0] count;
    acc_vec_t         nv;
    acc_vec_t         dx;
    acc_vec_t         de;
  } item_t;

  typedef struct packed {
    logic              mode;
    logic [CNT_W-1:0]  count;
    logic [MASK_W-1:0] mask;
    logic              bad;
  } ctrl_t;

  // Scales a product of two coordinates by 2^-k and rounds half up to
  // FRAC_BITS+3 fraction bits.
  function automatic logic signed [ACC_W-1:0] term(input logic signed [PROD_W-1:0] p,
                                                   input int k);
    logic signed [PROD_W:0] t;
    t = (PROD_W+1)'(p) + ((PROD_W+1)'(1) <<< (FRAC_BITS - 4 + k));
    return ACC_W'(t >>> (FRAC_BITS - 3 + k));
  endfunction

  // Rounds a sum back to FRAC_BITS fraction bits and saturates it.
  function automatic logic signed [OUT_W-1:0] finish(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W:0] t;
    logic signed [ACC_W:0] v;
    t = (ACC_W+1)'(acc) + (ACC_W+1)'(4);
    v = t >>> 3;
    if (v > (ACC_W+1)'(LIM)) begin
      return OUT_W'(LIM);
    end else if (v < -(ACC_W+1)'(LIM)) begin
      return -OUT_W'(LIM);
    end
    return OUT_W'(v);
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/serendipity_shape_eval_top.sv -----
// Top level of the serendipity shape evaluator for line and quadrilateral elements.
//
// The input channel (s_t*) takes one request per word: element type in s_tuser,
// coordinates, node count and midside mask in s_tdata. The output channel (m_t*)
// gives one word per node of the element, node 0 first, with m_tlast on the final
// word of a request. A request whose node count does not fit the element type
// gives one word with zero data, m_tuser high and m_tlast high.
// An accepted request reaches its first result word through three front-end
// stages (squares, products, products with the squared terms), a two-entry
// queue, and the output register. Results leave at one word per cycle while
// m_tready is high, and a request gives as many words as it has nodes (one for a
// rejected request), eight at most. The front end takes a new request every cycle
// while the queue has room; the output sequencer sets the sustained rate.
// Reset empties the pipeline, the queue and the output register. When the receiver
// holds m_tready low the current word stays, the queue fills, and then s_tready
// drops until words drain again.
`default_nettype none

module serendipity_shape_eval_top (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           s_tvalid,
  output logic                          s_tready,
  // xsi [15:0], eta [31:16], node_count [35:32], midside_mask [39:36]
  input  wire [sse_pkg::IN_DATA_W-1:0]  s_tdata,
  // mode [0]
  input  wire                           s_tuser,
  output logic                          m_tvalid,
  input  wire                           m_tready,
  // node_index [2:0], shape_value [19:3], deriv_xsi [36:20], deriv_eta [53:37]
  output logic [sse_pkg::OUT_DATA_W-1:0] m_tdata,
  // bad_request [0]
  output logic                          m_tuser,
  output logic                          m_tlast
);
  import sse_pkg::*;

  logic push, q_ready, head_valid, pop;
  item_t fe_item, head;

  sse_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .push     (push),
    .q_ready  (q_ready),
    .item     (fe_item)
  );

  sse_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .in_item    (fe_item),
    .q_ready    (q_ready),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  sse_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast)
  );

  // A rejected request is a single word with all data zero.
  a_bad_single: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tlast && (m_tdata == '0)))
    else $error("rejected request word is not a lone zero word");

  // Within a request the node index steps by one from word to word.
  a_node_step: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !m_tlast) |=>
      (!m_tvalid || (m_tdata[2:0] == $past(m_tdata[2:0]) + 3'd1)))
    else $error("node index did not advance by one");

  // The word after a final word starts a new request at node zero.
  a_node_restart: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tlast) |=> (!m_tvalid || (m_tdata[2:0] == 3'd0)))
    else $error("new request did not start at node zero");

  // The queue is never written while it is full.
  a_queue_room: assert property (@(posedge clk) disable iff (rst)
    push |-> q_ready)
    else $error("queue written while full");

endmodule

`default_nettype wire

// ----- hw/rtl/sse_front.sv -----
// Front end: accepts words, checks the request and computes all node sums in three stages.
`default_nettype none

module sse_front (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          s_tvalid,
  output logic                         s_tready,
  input  wire [sse_pkg::IN_DATA_W-1:0] s_tdata,
  input  wire                          s_tuser,
  output logic                         push,
  input  wire                          q_ready,
  output sse_pkg::item_t               item
);
  import sse_pkg::*;

  logic adv;
  logic v1, v2, v3;

  logic signed [COORD_W-1:0] x_in, e_in;
  logic signed [CW-1:0] x_ext, e_ext;
  logic signed [PROD_W-1:0] xx_in, ee_in;
  ctrl_t ctrl_in;

  ctrl_t c1, c2, c3;
  logic signed [CW-1:0] x1, e1, mx1, px1, me1, pe1;
  logic signed [PROD_W-1:0] xx1, ee1;

  logic signed [CW-1:0] x2, mx2, px2, me2, pe2, a2, b2;
  logic signed [PROD_W-1:0] s2, mxme2, pxme2, pxpe2, mxpe2, xme2, xpe2, epx2, emx2;
  logic signed [PROD_W-1:0] rx2_next, re2_next;

  logic signed [CW-1:0] x3, mx3, px3, me3, pe3, a3, b3;
  logic signed [PROD_W-1:0] s3, mxme3, pxme3, pxpe3, mxpe3, xme3, xpe3, epx3, emx3;
  logic signed [PROD_W-1:0] ame3, bpx3, ape3, bmx3;

  logic signed [PROD_W-1:0] one_sq, x_one, mx_one, px_one, me_one, pe_one, a_one, b_one;
  logic n3, m0, m1, m2, m3;

  assign adv = !v3 || q_ready;
  assign s_tready = adv;
  assign push = v3 && q_ready;

  assign x_in = $signed(s_tdata[15:0]);
  assign e_in = $signed(s_tdata[31:16]);
  assign x_ext = CW'(x_in);
  assign e_ext = CW'(e_in);
  assign xx_in = x_ext * x_ext;
  assign ee_in = e_ext * e_ext;

  always_comb begin
    ctrl_in.mode = s_tuser;
    ctrl_in.count = s_tdata[35:32];
    ctrl_in.mask = s_tdata[39:36];
    if (s_tuser == MODE_LINE) begin
      ctrl_in.bad = (ctrl_in.count != LINE_NODES_2) && (ctrl_in.count != LINE_NODES_3);
    end else begin
      ctrl_in.bad = (ctrl_in.count != QUAD_NODES_4) && (ctrl_in.count != QUAD_NODES_8);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (adv) begin
      v1 <= s_tvalid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  assign rx2_next = (xx1 + PROD_W'(ONE / 2)) >>> FRAC_BITS;
  assign re2_next = (ee1 + PROD_W'(ONE / 2)) >>> FRAC_BITS;

  always_ff @(posedge clk) begin
    if (adv) begin
      c1 <= ctrl_in;
      x1 <= x_ext;
      e1 <= e_ext;
      mx1 <= CW'(ONE) - x_ext;
      px1 <= CW'(ONE) + x_ext;
      me1 <= CW'(ONE) - e_ext;
      pe1 <= CW'(ONE) + e_ext;
      xx1 <= xx_in;
      ee1 <= ee_in;

      c2 <= c1;
      x2 <= x1;
      mx2 <= mx1;
      px2 <= px1;
      me2 <= me1;
      pe2 <= pe1;
      a2 <= CW'(ONE) - CW'(rx2_next);
      b2 <= CW'(ONE) - CW'(re2_next);
      s2 <= one_sq - xx1;
      mxme2 <= mx1 * me1;
      pxme2 <= px1 * me1;
      pxpe2 <= px1 * pe1;
      mxpe2 <= mx1 * pe1;
      xme2 <= x1 * me1;
      xpe2 <= x1 * pe1;
      epx2 <= e1 * px1;
      emx2 <= e1 * mx1;

      c3 <= c2;
      x3 <= x2;
      mx3 <= mx2;
      px3 <= px2;
      me3 <= me2;
      pe3 <= pe2;
      a3 <= a2;
      b3 <= b2;
      s3 <= s2;
      mxme3 <= mxme2;
      pxme3 <= pxme2;
      pxpe3 <= pxpe2;
      mxpe3 <= mxpe2;
      xme3 <= xme2;
      xpe3 <= xpe2;
      epx3 <= epx2;
      emx3 <= emx2;
      ame3 <= a2 * me2;
      bpx3 <= b2 * px2;
      ape3 <= a2 * pe2;
      bmx3 <= b2 * mx2;
    end
  end

  assign one_sq = PROD_W'(ONE) <<< FRAC_BITS;
  assign x_one = PROD_W'(x3) <<< FRAC_BITS;
  assign mx_one = PROD_W'(mx3) <<< FRAC_BITS;
  assign px_one = PROD_W'(px3) <<< FRAC_BITS;
  assign me_one = PROD_W'(me3) <<< FRAC_BITS;
  assign pe_one = PROD_W'(pe3) <<< FRAC_BITS;
  assign a_one = PROD_W'(a3) <<< FRAC_BITS;
  assign b_one = PROD_W'(b3) <<< FRAC_BITS;

  assign n3 = (c3.count == LINE_NODES_3);
  assign m0 = (c3.count == QUAD_NODES_8) && c3.mask[0];
  assign m1 = (c3.count == QUAD_NODES_8) && c3.mask[1];
  assign m2 = (c3.count == QUAD_NODES_8) && c3.mask[2];
  assign m3 = (c3.count == QUAD_NODES_8) && c3.mask[3];

  function automatic logic signed [ACC_W-1:0] gate(input logic en,
                                                   input logic signed [ACC_W-1:0] t);
    return en ? t : '0;
  endfunction

  always_comb begin
    logic signed [ACC_W-1:0] t_s1, t_x0;
    logic signed [ACC_W-1:0] t_ame2, t_bpx2, t_ape2, t_bmx2;
    logic signed [ACC_W-1:0] t_nxme1, t_nxpe1, t_b12, t_nb12, t_na12, t_a12;
    logic signed [ACC_W-1:0] t_nepx1, t_nemx1;
    t_s1 = gate(n3, term(s3, 1));
    t_x0 = gate(n3, term(x_one, 0));
    t_ame2 = gate(m0, term(ame3, 2));
    t_bpx2 = gate(m1, term(bpx3, 2));
    t_ape2 = gate(m2, term(ape3, 2));
    t_bmx2 = gate(m3, term(bmx3, 2));
    t_nxme1 = gate(m0, term(-xme3, 1));
    t_nxpe1 = gate(m2, term(-xpe3, 1));
    t_b12 = gate(m1, term(b_one, 2));
    t_nb12 = gate(m3, term(-b_one, 2));
    t_na12 = gate(m0, term(-a_one, 2));
    t_a12 = gate(m2, term(a_one, 2));
    t_nepx1 = gate(m1, term(-epx3, 1));
    t_nemx1 = gate(m3, term(-emx3, 1));

    item.bad = c3.bad;
    item.count = c3.bad ? CNT_W'(1) : c3.count;
    item.nv = '0;
    item.dx = '0;
    item.de = '0;

    if (c3.mode == MODE_LINE) begin
      item.nv[0] = term(mx_one, 1) - t_s1;
      item.nv[1] = term(px_one, 1) - t_s1;
      item.nv[2] = gate(n3, term(s3, 0));
      item.dx[0] = term(-one_sq, 1) + t_x0;
      item.dx[1] = term(one_sq, 1) + t_x0;
      item.dx[2] = gate(n3, term(-x_one, -1));
    end else begin
      item.nv[0] = term(mxme3, 2) - t_ame2 - t_bmx2;
      item.nv[1] = term(pxme3, 2) - t_ame2 - t_bpx2;
      item.nv[2] = term(pxpe3, 2) - t_bpx2 - t_ape2;
      item.nv[3] = term(mxpe3, 2) - t_ape2 - t_bmx2;
      item.nv[4] = gate(m0, term(ame3, 1));
      item.nv[5] = gate(m1, term(bpx3, 1));
      item.nv[6] = gate(m2, term(ape3, 1));
      item.nv[7] = gate(m3, term(bmx3, 1));

      item.dx[0] = term(-me_one, 2) - t_nxme1 - t_nb12;
      item.dx[1] = term(me_one, 2) - t_nxme1 - t_b12;
      item.dx[2] = term(pe_one, 2) - t_b12 - t_nxpe1;
      item.dx[3] = term(-pe_one, 2) - t_nxpe1 - t_nb12;
      item.dx[4] = gate(m0, term(-xme3, 0));
      item.dx[5] = gate(m1, term(b_one, 1));
      item.dx[6] = gate(m2, term(-xpe3, 0));
      item.dx[7] = gate(m3, term(-b_one, 1));

      item.de[0] = term(-mx_one, 2) - t_na12 - t_nemx1;
      item.de[1] = term(-px_one, 2) - t_na12 - t_nepx1;
      item.de[2] = term(px_one, 2) - t_nepx1 - t_a12;
      item.de[3] = term(mx_one, 2) - t_a12 - t_nemx1;
      item.de[4] = gate(m0, term(-a_one, 1));
      item.de[5] = gate(m1, term(-epx3, 0));
      item.de[6] = gate(m2, term(a_one, 1));
      item.de[7] = gate(m3, term(-emx3, 0));
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/sse_queue.sv -----
// Short queue of computed items between the front end and the result sequencer.
`default_nettype none

module sse_queue (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 push,
  input  wire sse_pkg::item_t in_item,
  output logic                q_ready,
  output logic                head_valid,
  output sse_pkg::item_t      head,
  input  wire                 pop
);
  import sse_pkg::*;

  item_t mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;

  assign q_ready = (count != QCNT_W'(QDEPTH));
  assign head_valid = (count != '0);
  assign head = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_item;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/sse_back.sv -----
// Back end: walks the nodes of the head item and drives one result word per cycle while the receiver takes words.
`default_nettype none

module sse_back (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           head_valid,
  input  wire sse_pkg::item_t           head,
  output logic                          pop,
  output logic                          m_tvalid,
  input  wire                           m_tready,
  output logic [sse_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic                          m_tuser,
  output logic                          m_tlast
);
  import sse_pkg::*;

  logic [NODE_W-1:0] idx;
  logic emit, is_last;
  logic signed [OUT_W-1:0] nv_q, dx_q, de_q;

  assign emit = head_valid && (!m_tvalid || m_tready);
  assign is_last = (CNT_W'(idx) + CNT_W'(1)) == head.count;
  assign pop = emit && is_last;

  always_comb begin
    if (head.bad) begin
      nv_q = '0;
      dx_q = '0;
      de_q = '0;
    end else begin
      nv_q = finish($signed(head.nv[idx]));
      dx_q = finish($signed(head.dx[idx]));
      de_q = finish($signed(head.de[idx]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (emit) begin
        m_tvalid <= 1'b1;
        idx <= is_last ? '0 : idx + NODE_W'(1);
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata <= {{(OUT_DATA_W - NODE_W - 3 * OUT_W){1'b0}}, de_q, dx_q, nv_q,
                  head.bad ? NODE_W'(0) : idx};
      m_tuser <= head.bad;
      m_tlast <= is_last;
    end
  end

endmodule

`default_nettype wire
